// ===== sv/ipv4_header_generator_macros.svh =====
// ============================================================================
// IPv4 header generator assertion macros
// Concurrent assertion wrappers for the IPv4 header generator. The checking
// forms are compiled for simulation only and are empty for synthesis.
// ============================================================================
`ifndef IPV4_HEADER_GENERATOR_MACROS_SVH
`define IPV4_HEADER_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold at every clock edge at which the antecedent holds.
`define IPV4HG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv4 header generator: implication check failed");

// The expression must never be true at a clock edge.
`define IPV4HG_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ipv4 header generator: forbidden condition seen");

`else

`define IPV4HG_ASSERT_IMPL(label, ante, cons)
`define IPV4HG_ASSERT_NEVER(label, expr)

`endif

`endif

// ===== sv/ipv4hg_pkg.sv =====
// ============================================================================
// IPv4 header generator package
// Transfer types, header record and constants shared by the generator.
// ============================================================================
package ipv4hg_pkg;

    // Request transfer: one packet to be given a header.
    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  protocol;
        logic [31:0] source_addr;
        logic [31:0] dst_addr;
    } req_t;

    // Result transfer: one header word.
    typedef struct packed {
        logic [2:0]  word_index;
        logic [31:0] header_word;
        logic        last_word;
    } hdr_word_t;

    // A finished header, as held in the queue between front and back.
    typedef struct packed {
        logic [7:0]  tos;
        logic [15:0] tot_len;
        logic [15:0] ident;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [15:0] checksum;
        logic [31:0] source_addr;
        logic [31:0] dst_addr;
    } hdr_rec_t;

    // Queue status seen by both of its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]  VERSION_IHL = 8'h45;
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [2:0]  WORD_FIRST  = 3'd0;
    localparam logic [2:0]  WORD_IDENT  = 3'd1;
    localparam logic [2:0]  WORD_TTL    = 3'd2;
    localparam logic [2:0]  WORD_SRC    = 3'd3;
    localparam logic [2:0]  WORD_LAST   = 3'd4;

    // Configuration port.
    localparam int          APB_ADDR_W = 3;
    localparam logic        REG_TTL    = 1'b0;
    localparam logic        REG_TOS    = 1'b1;
    localparam logic [7:0]  TTL_RESET  = 8'd30;
    localparam logic [7:0]  TOS_RESET  = 8'd0;

endpackage

// ===== sv/ipv4hg_front.sv =====
// ============================================================================
// IPv4 header generator front end
// Accepts packet requests, assigns identification numbers and computes the
// header checksum across its stage register before queueing the header.
// ============================================================================
module ipv4hg_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  ipv4hg_pkg::req_t       req,
    input  logic [7:0]             ttl,
    input  logic [7:0]             tos,
    input  ipv4hg_pkg::fifo_stat_t fifo_stat,
    output logic                   push,
    output ipv4hg_pkg::hdr_rec_t   push_rec
);

    logic                 stage_valid_reg;
    logic [15:0]          ident_reg;
    logic [15:0]          ident_next;
    ipv4hg_pkg::hdr_rec_t stage_reg;
    logic [18:0]          psum_reg;
    logic [18:0]          psum_next;
    logic [15:0]          total_next;
    logic                 accept;
    logic [19:0]          full_sum;
    logic [16:0]          fold1;
    logic [15:0]          fold2;

    assign push      = stage_valid_reg && !fifo_stat.full;
    assign req_stall = stage_valid_reg && fifo_stat.full;
    assign accept    = req_valid && !req_stall;

    assign ident_next = ident_reg + 16'd1;
    assign total_next = req.payload_length + ipv4hg_pkg::HDR_BYTES;

    // Everything but the total length is summed in the accept cycle.
    assign psum_next = 19'({ipv4hg_pkg::VERSION_IHL, tos})
                     + 19'(ident_reg)
                     + 19'({ttl, req.protocol})
                     + 19'(req.source_addr[31:16])
                     + 19'(req.source_addr[15:0])
                     + 19'(req.dst_addr[31:16])
                     + 19'(req.dst_addr[15:0]);

    // Second stage: add the total length, fold the carries twice and invert.
    assign full_sum = 20'(psum_reg) + 20'(stage_reg.tot_len);
    assign fold1    = 17'(full_sum[15:0]) + 17'(full_sum[19:16]);
    assign fold2    = fold1[15:0] + 16'(fold1[16]);

    always_comb
    begin
        push_rec          = stage_reg;
        push_rec.checksum = ~fold2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            ident_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
                ident_reg       <= ident_next;
            end
            else if (push)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.tos          <= tos;
            stage_reg.tot_len      <= total_next;
            stage_reg.ident        <= ident_reg;
            stage_reg.ttl          <= ttl;
            stage_reg.protocol     <= req.protocol;
            stage_reg.checksum     <= '0;
            stage_reg.source_addr  <= req.source_addr;
            stage_reg.dst_addr     <= req.dst_addr;
            psum_reg               <= psum_next;
        end
    end

endmodule

// ===== sv/ipv4hg_fifo.sv =====
// ============================================================================
// IPv4 header generator header queue
// Short queue of finished headers between the front end and the word emitter.
// ============================================================================
module ipv4hg_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ipv4hg_pkg::hdr_rec_t   push_rec,
    input  logic                   pop,
    output ipv4hg_pkg::hdr_rec_t   head,
    output ipv4hg_pkg::fifo_stat_t fifo_stat
);

    ipv4hg_pkg::hdr_rec_t                 entry_reg [ipv4hg_pkg::FIFO_DEPTH];
    logic [ipv4hg_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [ipv4hg_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [ipv4hg_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [ipv4hg_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [ipv4hg_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;

    localparam logic [ipv4hg_pkg::FIFO_PTR_W-1:0] PtrLast =
        ipv4hg_pkg::FIFO_PTR_W'(ipv4hg_pkg::FIFO_DEPTH - 1);
    localparam logic [ipv4hg_pkg::FIFO_CNT_W-1:0] CntFull =
        ipv4hg_pkg::FIFO_CNT_W'(ipv4hg_pkg::FIFO_DEPTH);

    assign wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;

    assign head            = entry_reg[rd_ptr_reg];
    assign fifo_stat.full  = (count_reg == CntFull);
    assign fifo_stat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== sv/ipv4hg_back.sv =====
// ============================================================================
// IPv4 header generator word emitter
// Walks the header at the head of the queue one 32-bit word per transfer
// into an output register, releasing the entry with its last word.
// ============================================================================
module ipv4hg_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ipv4hg_pkg::hdr_rec_t    head,
    input  ipv4hg_pkg::fifo_stat_t  fifo_stat,
    output logic                    pop,
    output logic                    hdr_valid,
    input  logic                    hdr_stall,
    output ipv4hg_pkg::hdr_word_t   hdr
);

    logic                  hdr_valid_reg;
    ipv4hg_pkg::hdr_word_t hdr_reg;
    logic [2:0]            idx_reg;
    logic [2:0]            idx_next;
    logic                  load;
    logic                  is_last;
    logic [31:0]           word_sel;

    assign load     = !fifo_stat.empty && (!hdr_valid_reg || !hdr_stall);
    assign is_last  = (idx_reg == ipv4hg_pkg::WORD_LAST);
    assign pop      = load && is_last;
    assign idx_next = is_last ? ipv4hg_pkg::WORD_FIRST : idx_reg + 3'd1;

    assign hdr_valid = hdr_valid_reg;
    assign hdr       = hdr_reg;

    always_comb
    begin
        case (idx_reg)
            ipv4hg_pkg::WORD_FIRST: word_sel = {ipv4hg_pkg::VERSION_IHL, head.tos,
                                                head.tot_len};
            ipv4hg_pkg::WORD_IDENT: word_sel = {head.ident, 16'h0000};
            ipv4hg_pkg::WORD_TTL:   word_sel = {head.ttl, head.protocol, head.checksum};
            ipv4hg_pkg::WORD_SRC:   word_sel = head.source_addr;
            ipv4hg_pkg::WORD_LAST:  word_sel = head.dst_addr;
            default:                word_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= 1'b0;
            idx_reg       <= ipv4hg_pkg::WORD_FIRST;
        end
        else
        begin
            if (load)
            begin
                hdr_valid_reg <= 1'b1;
                idx_reg       <= idx_next;
            end
            else if (!hdr_stall)
            begin
                hdr_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg.word_index  <= idx_reg;
            hdr_reg.header_word <= word_sel;
            hdr_reg.last_word   <= is_last;
        end
    end

endmodule

// ===== sv/ipv4_header_generator.sv =====
// ============================================================================
// IPv4 header generator
// Builds a 20-byte IPv4 header for each packet request and emits it as five
// big-endian 32-bit words.
// ============================================================================
// Each request transfer (payload length, protocol, source and destination
// address) yields five header transfers on the hdr channel, word_index 0 to
// 4, with last_word set on the fifth. Version 4 and IHL 5 are fixed, flags
// and fragment offset are zero, TOS and TTL come from the registers at
// address 0x4 and 0x0, and the identification field is a 16-bit counter that
// starts at zero after reset and advances by one per request. Total length is
// the payload length plus 20, modulo 65536. The checksum is the folded,
// inverted ones'-complement sum of the header. Sustained rate is set by the
// 32-bit result channel, which carries one header word per cycle while
// hdr_stall is low; requests are taken back to back while earlier
// headers are still being emitted, as long as the two-entry header queue has
// room. The request is registered with its partial checksum when it is
// accepted, the finished header is then written into the queue, and the
// output register is loaded from the head of the queue. Registers
// should only be written while no packet is in flight.
// ============================================================================
`include "ipv4_header_generator_macros.svh"

module ipv4_header_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipv4hg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Packet requests.
    input  logic                                req_valid,
    output logic                                req_stall,
    input  ipv4hg_pkg::req_t                    req,
    // Header words.
    output logic                                hdr_valid,
    input  logic                                hdr_stall,
    output ipv4hg_pkg::hdr_word_t               hdr
);

    logic [7:0]             ttl_reg;
    logic [7:0]             tos_reg;
    logic                   cfg_write;
    logic                   reg_sel;
    logic                   push;
    logic                   pop;
    ipv4hg_pkg::hdr_rec_t   push_rec;
    ipv4hg_pkg::hdr_rec_t   head;
    ipv4hg_pkg::fifo_stat_t fifo_stat;
    logic                   hdr_at_last;
    logic                   mid_xfer;
    logic [2:0]             idx_step;

    // Registers sit on 32-bit boundaries; the word address picks one of two.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[ipv4hg_pkg::APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            ipv4hg_pkg::REG_TTL: prdata = 32'(ttl_reg);
            ipv4hg_pkg::REG_TOS: prdata = 32'(tos_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= ipv4hg_pkg::TTL_RESET;
            tos_reg <= ipv4hg_pkg::TOS_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                ipv4hg_pkg::REG_TTL: ttl_reg <= pwdata[7:0];
                ipv4hg_pkg::REG_TOS: tos_reg <= pwdata[7:0];
                default:             ttl_reg <= ttl_reg;
            endcase
        end
    end

    // The front end takes requests and finishes each header's checksum.
    ipv4hg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .ttl       (ttl_reg),
        .tos       (tos_reg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_rec  (push_rec)
    );

    // The queue lets the front end keep accepting while words drain.
    ipv4hg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .head      (head),
        .fifo_stat (fifo_stat)
    );

    // The back end turns each queued header into five word transfers.
    ipv4hg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr       (hdr)
    );

    // Helpers for the checks below: a taken word that is not the last, and
    // the index that must follow it.
    assign hdr_at_last = (hdr.word_index == ipv4hg_pkg::WORD_LAST);
    assign mid_xfer    = hdr_valid && !hdr_stall && !hdr.last_word;
    assign idx_step    = hdr.word_index + 3'd1;

    // A header must never be pushed into a full queue.
    `IPV4HG_ASSERT_NEVER(a_no_push_when_full, push && fifo_stat.full)

    // The last-word flag marks exactly the fifth word.
    `IPV4HG_ASSERT_IMPL(a_last_is_fifth, hdr_valid, hdr.last_word == hdr_at_last)

    // After a word other than the last is taken, the next word follows in order.
    `IPV4HG_ASSERT_IMPL(a_word_order, hdr_valid && $past(mid_xfer), hdr.word_index == $past(idx_step))

    // A queue entry is released only together with its last word; the check asserts the queue is not empty then.
    `IPV4HG_ASSERT_IMPL(a_pop_on_last, pop, !fifo_stat.empty)

endmodule
